// ----- rtl/core/alignment_pair_column_scorer_defines.svh -----
// Assertion macros used by the scorer's top-level RTL file.
`ifndef ALIGNMENT_PAIR_COLUMN_SCORER_DEFINES_SVH
`define ALIGNMENT_PAIR_COLUMN_SCORER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define APCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define APCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/apcs_pkg.sv -----
// Shared types and constants of the pair and column scorer.
package apcs_pkg;

    localparam int COL_W      = 12;
    localparam int CFG_SEQ_W  = 7;
    localparam int PAIR_W     = 23;
    localparam int COLW_W     = 19;
    localparam int SUM_W      = 32;
    localparam int SEEN_W     = 13;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_SEQ_W-1:0] SEQ_RESET = 7'd2;
    localparam logic [SEEN_W-1:0]    SEEN_MAX  = '1;

    // Register index decoded from paddr[APB_ADDR_W-1:2].
    localparam logic [APB_ADDR_W-3:0] REG_BLOCK_SEQUENCES = '0;

    typedef struct packed {
        logic             ref_residue;
        logic [COL_W-1:0] test_column;
        logic             block_end;
    } entry_t;

    typedef struct packed {
        logic              block_counted;
        logic [PAIR_W-1:0] block_pairs_matched;
        logic [PAIR_W-1:0] block_pairs_total;
        logic [COLW_W-1:0] block_columns_matched;
        logic [COLW_W-1:0] block_columns_total;
        logic [SUM_W-1:0]  sum_pairs_matched;
        logic [SUM_W-1:0]  sum_pairs_total;
        logic [SUM_W-1:0]  sum_columns_matched;
        logic [SUM_W-1:0]  sum_columns_total;
    } result_t;

endpackage

// ----- rtl/core/apcs_cell.sv -----
// One cell of the scoring chain: holds one column entry and counts pairs for a passing token.
module apcs_cell #(
    parameter int          IDX_W    = 6,
    parameter int unsigned CELL_IDX = 0,
    parameter type         tok_t    = logic
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic advance,
    input  tok_t tok_in,
    output tok_t tok_out
);
    import apcs_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic             ent_res_reg;
    logic [COL_W-1:0] ent_col_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             pair_hit;
    logic             pair_match;
    logic             ent_write;

    // Only entries placed earlier in the current column sit below the token's index.
    assign pair_hit   = tok_in.valid && tok_in.res && (MY_IDX < tok_in.idx) && ent_res_reg;
    assign pair_match = pair_hit && (ent_col_reg == tok_in.col);
    assign ent_write  = advance && tok_in.valid && (tok_in.idx == MY_IDX);

    always_comb begin
        tok_next         = tok_in;
        tok_next.total   = tok_in.total + IDX_W'(pair_hit);
        tok_next.matched = tok_in.matched + IDX_W'(pair_match);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (advance) begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ent_write) begin
            ent_res_reg <= tok_in.res;
            ent_col_reg <= tok_in.col;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- rtl/core/apcs_tally.sv -----
// Column, block and running-total accumulation stages behind the cell chain, with the result register.
module apcs_tally #(
    parameter int  MAX_SEQUENCES = 64,
    parameter type tok_t         = logic
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tok_t              tok_in,
    input  logic              m_ready,
    output logic              advance,
    output logic              m_valid,
    output apcs_pkg::result_t m_data
);
    import apcs_pkg::*;

    localparam int NW           = $clog2(MAX_SEQUENCES + 1);
    localparam int PAIR_COL_MAX = MAX_SEQUENCES * (MAX_SEQUENCES - 1) / 2;
    localparam int CPW          = $clog2(PAIR_COL_MAX + 1);

    typedef struct packed {
        logic           valid;
        logic [CPW-1:0] ct;
        logic [CPW-1:0] cm;
        logic [NW-1:0]  n;
        logic           blk_end;
    } col_rec_t;

    typedef struct packed {
        logic              valid;
        logic              counted;
        logic [PAIR_W-1:0] pm;
        logic [PAIR_W-1:0] pt;
        logic [COLW_W-1:0] cm;
        logic [COLW_W-1:0] ct;
    } blk_rec_t;

    // Column stage.
    logic [CPW-1:0] col_total_reg, col_total_next;
    logic [CPW-1:0] col_matched_reg, col_matched_next;
    logic [CPW-1:0] ct_sum, cm_sum;
    col_rec_t       rec1_reg, rec1_next;

    // Block stage.
    logic [PAIR_W-1:0] bpm_reg, bpm_next, bpt_reg, bpt_next;
    logic [COLW_W-1:0] bcm_reg, bcm_next, bct_reg, bct_next;
    logic [SEEN_W-1:0] seen_reg, seen_next, seen_inc;
    logic [PAIR_W:0]   bpm_sum, bpt_sum;
    logic [COLW_W:0]   bcm_sum, bct_sum;
    logic [PAIR_W-1:0] bpm_new, bpt_new;
    logic [COLW_W-1:0] bcm_new, bct_new;
    logic              col_has_pair;
    blk_rec_t          rec2_reg, rec2_next;

    // Running-total stage.
    logic [SUM_W-1:0] rpm_reg, rpm_next, rpt_reg, rpt_next;
    logic [SUM_W-1:0] rcm_reg, rcm_next, rct_reg, rct_next;
    logic [SUM_W:0]   rpm_sum, rpt_sum, rcm_sum, rct_sum;
    logic             m_valid_reg;
    result_t          m_data_reg, m_data_next;

    // A waiting result holds the whole pipeline.
    assign advance = !m_valid_reg || m_ready;

    always_comb begin
        ct_sum           = col_total_reg + CPW'(tok_in.total);
        cm_sum           = col_matched_reg + CPW'(tok_in.matched);
        col_total_next   = col_total_reg;
        col_matched_next = col_matched_reg;
        rec1_next.valid  = tok_in.valid && tok_in.close;
        rec1_next.ct     = ct_sum;
        rec1_next.cm     = cm_sum;
        rec1_next.n      = tok_in.n;
        rec1_next.blk_end = tok_in.blk_end;
        if (tok_in.valid) begin
            if (tok_in.close) begin
                col_total_next   = '0;
                col_matched_next = '0;
            end else begin
                col_total_next   = ct_sum;
                col_matched_next = cm_sum;
            end
        end
    end

    always_comb begin
        col_has_pair = (rec1_reg.ct != '0);
        bpm_sum = {1'b0, bpm_reg} + (PAIR_W + 1)'(rec1_reg.cm);
        bpt_sum = {1'b0, bpt_reg} + (PAIR_W + 1)'(rec1_reg.ct);
        bct_sum = {1'b0, bct_reg} + (COLW_W + 1)'(rec1_reg.n);
        bcm_sum = bct_sum - (COLW_W + 1)'(bct_reg) + (COLW_W + 1)'(bcm_reg);
        bpm_new = bpm_sum[PAIR_W] ? '1 : bpm_sum[PAIR_W-1:0];
        bpt_new = bpt_sum[PAIR_W] ? '1 : bpt_sum[PAIR_W-1:0];
        bct_new = bct_reg;
        bcm_new = bcm_reg;
        if (col_has_pair) begin
            bct_new = bct_sum[COLW_W] ? '1 : bct_sum[COLW_W-1:0];
            if (rec1_reg.cm == rec1_reg.ct) begin
                bcm_new = bcm_sum[COLW_W] ? '1 : bcm_sum[COLW_W-1:0];
            end
        end
        seen_inc = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + SEEN_W'(1);

        rec2_next.valid   = rec1_reg.valid && rec1_reg.blk_end;
        rec2_next.counted = (seen_inc > SEEN_W'(1));
        rec2_next.pm      = bpm_new;
        rec2_next.pt      = bpt_new;
        rec2_next.cm      = bcm_new;
        rec2_next.ct      = bct_new;

        bpm_next  = bpm_reg;
        bpt_next  = bpt_reg;
        bcm_next  = bcm_reg;
        bct_next  = bct_reg;
        seen_next = seen_reg;
        if (rec1_reg.valid) begin
            if (rec1_reg.blk_end) begin
                bpm_next  = '0;
                bpt_next  = '0;
                bcm_next  = '0;
                bct_next  = '0;
                seen_next = '0;
            end else begin
                bpm_next  = bpm_new;
                bpt_next  = bpt_new;
                bcm_next  = bcm_new;
                bct_next  = bct_new;
                seen_next = seen_inc;
            end
        end
    end

    always_comb begin
        rpm_sum  = {1'b0, rpm_reg} + (SUM_W + 1)'(rec2_reg.pm);
        rpt_sum  = {1'b0, rpt_reg} + (SUM_W + 1)'(rec2_reg.pt);
        rcm_sum  = {1'b0, rcm_reg} + (SUM_W + 1)'(rec2_reg.cm);
        rct_sum  = {1'b0, rct_reg} + (SUM_W + 1)'(rec2_reg.ct);
        rpm_next = rpm_reg;
        rpt_next = rpt_reg;
        rcm_next = rcm_reg;
        rct_next = rct_reg;
        if (rec2_reg.valid && rec2_reg.counted) begin
            rpm_next = rpm_sum[SUM_W] ? '1 : rpm_sum[SUM_W-1:0];
            rpt_next = rpt_sum[SUM_W] ? '1 : rpt_sum[SUM_W-1:0];
            rcm_next = rcm_sum[SUM_W] ? '1 : rcm_sum[SUM_W-1:0];
            rct_next = rct_sum[SUM_W] ? '1 : rct_sum[SUM_W-1:0];
        end
        m_data_next.block_counted         = rec2_reg.counted;
        m_data_next.block_pairs_matched   = rec2_reg.pm;
        m_data_next.block_pairs_total     = rec2_reg.pt;
        m_data_next.block_columns_matched = rec2_reg.cm;
        m_data_next.block_columns_total   = rec2_reg.ct;
        m_data_next.sum_pairs_matched     = rpm_next;
        m_data_next.sum_pairs_total       = rpt_next;
        m_data_next.sum_columns_matched   = rcm_next;
        m_data_next.sum_columns_total     = rct_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_total_reg   <= '0;
            col_matched_reg <= '0;
            rec1_reg.valid  <= 1'b0;
            bpm_reg         <= '0;
            bpt_reg         <= '0;
            bcm_reg         <= '0;
            bct_reg         <= '0;
            seen_reg        <= '0;
            rec2_reg.valid  <= 1'b0;
            rpm_reg         <= '0;
            rpt_reg         <= '0;
            rcm_reg         <= '0;
            rct_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else if (advance) begin
            col_total_reg   <= col_total_next;
            col_matched_reg <= col_matched_next;
            rec1_reg        <= rec1_next;
            bpm_reg         <= bpm_next;
            bpt_reg         <= bpt_next;
            bcm_reg         <= bcm_next;
            bct_reg         <= bct_next;
            seen_reg        <= seen_next;
            rec2_reg        <= rec2_next;
            rpm_reg         <= rpm_next;
            rpt_reg         <= rpt_next;
            rcm_reg         <= rcm_next;
            rct_reg         <= rct_next;
            m_valid_reg     <= rec2_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && rec2_reg.valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/core/alignment_pair_column_scorer.sv -----
// Top level of the sum-of-pairs and total-column scorer: entry intake, cell chain, tally and APB.
//
// Takes one column entry per clock cycle for as long as the result side keeps up. Each entry
// enters a chain of MAX_SEQUENCES cells, one cell per cycle; cell k holds entry k of the current
// column and counts the pairs the passing entry forms with it. Three tally stages then add the
// per-column, per-block and running totals; the last of them registers a block's result beat.
// A result beat that is not taken holds the whole chain and s_ready drops. block_sequences is
// sampled as each entry is accepted, clamped to the range 2 to MAX_SEQUENCES; it sits at byte
// address 0 of the APB port.
`include "alignment_pair_column_scorer_defines.svh"

module alignment_pair_column_scorer #(
    parameter int MAX_SEQUENCES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  apcs_pkg::entry_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output apcs_pkg::result_t                   m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [apcs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [apcs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [apcs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import apcs_pkg::*;

    localparam int IDX_W = $clog2(MAX_SEQUENCES);
    localparam int NW    = $clog2(MAX_SEQUENCES + 1);

    typedef struct packed {
        logic             valid;
        logic             res;
        logic [COL_W-1:0] col;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] total;
        logic [IDX_W-1:0] matched;
        logic             close;
        logic             blk_end;
        logic [NW-1:0]    n;
    } tok_t;

    logic                  advance;
    logic                  accept;
    logic                  cfg_write;
    logic                  cfg_sel;
    logic [CFG_SEQ_W-1:0]  seq_reg;
    logic [IDX_W-1:0]      entry_index_reg, entry_index_next;
    logic [NW-1:0]         n_use;
    logic [IDX_W-1:0]      idx_cur;
    logic [NW-1:0]         idx_inc;
    logic                  col_close;
    tok_t                  chain_tok [MAX_SEQUENCES+1];

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_sel   = (paddr[APB_ADDR_W-1:2] == REG_BLOCK_SEQUENCES);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = cfg_sel ? APB_DATA_W'(seq_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg <= SEQ_RESET;
        end else if (cfg_write && cfg_sel) begin
            seq_reg <= pwdata[CFG_SEQ_W-1:0];
        end
    end

    // Entry intake: place of the entry within its column.
    assign s_ready = advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (seq_reg < CFG_SEQ_W'(2)) begin
            n_use = NW'(2);
        end else if (32'(seq_reg) > 32'(MAX_SEQUENCES)) begin
            n_use = NW'(MAX_SEQUENCES);
        end else begin
            n_use = NW'(seq_reg);
        end
    end

    always_comb begin
        // A column size lowered mid-column makes the last slot overwrite itself.
        if (NW'(entry_index_reg) >= n_use) begin
            idx_cur = IDX_W'(n_use - NW'(1));
        end else begin
            idx_cur = entry_index_reg;
        end
        idx_inc          = NW'(idx_cur) + NW'(1);
        col_close        = (idx_inc >= n_use) || s_data.block_end;
        entry_index_next = col_close ? '0 : IDX_W'(idx_inc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_index_reg <= '0;
        end else if (accept) begin
            entry_index_reg <= entry_index_next;
        end
    end

    always_comb begin
        chain_tok[0].valid   = accept;
        chain_tok[0].res     = s_data.ref_residue;
        chain_tok[0].col     = s_data.test_column;
        chain_tok[0].idx     = idx_cur;
        chain_tok[0].total   = '0;
        chain_tok[0].matched = '0;
        chain_tok[0].close   = col_close;
        chain_tok[0].blk_end = s_data.block_end;
        chain_tok[0].n       = n_use;
    end

    for (genvar k = 0; k < MAX_SEQUENCES; k++) begin : g_cell
        apcs_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (k),
            .tok_t    (tok_t)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .tok_in  (chain_tok[k]),
            .tok_out (chain_tok[k+1])
        );
    end

    apcs_tally #(
        .MAX_SEQUENCES (MAX_SEQUENCES),
        .tok_t         (tok_t)
    ) u_tally (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tok_in  (chain_tok[MAX_SEQUENCES]),
        .m_ready (m_ready),
        .advance (advance),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    `APCS_ASSERT_NEXT(a_block_end_rewinds, aclk, aresetn, accept && s_data.block_end, entry_index_reg == '0, "entry index not cleared after block end")
    `APCS_ASSERT_NEXT(a_index_in_column, aclk, aresetn, accept && !s_data.block_end, NW'(entry_index_reg) < $past(n_use), "entry index beyond column size")
    `APCS_ASSERT_NOW(a_matched_within_total, aclk, aresetn, m_valid, (m_data.block_pairs_matched <= m_data.block_pairs_total) && (m_data.block_columns_matched <= m_data.block_columns_total), "matched count exceeds total")
    `APCS_ASSERT_NOW(a_sum_covers_block, aclk, aresetn, m_valid && m_data.block_counted, m_data.sum_pairs_total >= SUM_W'(m_data.block_pairs_total), "running total below counted block")

endmodule

// ----- tb/alignment_pair_column_scorer_test.sv -----
// Self-checking testbench for the pair and column scorer, with its own score predictor.
`timescale 1ns / 1ps

module alignment_pair_column_scorer_test;
    import apcs_pkg::*;

    localparam int MAX_SEQ = 64;
    localparam int SETTLE_CYCLES = MAX_SEQ + 2 + 12;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_CYCLES = 400;
    localparam int LONG_COLS = 60;
    localparam longint unsigned PAIR_CAP = (64'd1 << PAIR_W) - 1;
    localparam longint unsigned COLW_CAP = (64'd1 << COLW_W) - 1;
    localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 1;
    localparam logic [APB_ADDR_W-1:0] SEQ_ADDR = {REG_BLOCK_SEQUENCES, 2'b00};
    localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = {~REG_BLOCK_SEQUENCES, 2'b00};

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    entry_t s_data;
    logic m_valid;
    logic m_ready;
    result_t m_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    alignment_pair_column_scorer #(
        .MAX_SEQUENCES(MAX_SEQ)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Predictor state: the register copy and the scorer's own counters.
    logic [CFG_SEQ_W-1:0] seq_reg;
    logic held_residue [MAX_SEQ];
    logic [COL_W-1:0] held_column [MAX_SEQ];
    int unsigned slot;
    logic [10:0] col_pairs;
    logic [10:0] col_matched;
    logic [SEEN_W-1:0] cols_in_block;
    logic [PAIR_W-1:0] blk_pairs_matched;
    logic [PAIR_W-1:0] blk_pairs_total;
    logic [COLW_W-1:0] blk_cols_matched;
    logic [COLW_W-1:0] blk_cols_total;
    logic [SUM_W-1:0] run_pairs_matched;
    logic [SUM_W-1:0] run_pairs_total;
    logic [SUM_W-1:0] run_cols_matched;
    logic [SUM_W-1:0] run_cols_total;

    result_t expected_blocks [$];

    int unsigned fail_count = 0;
    int unsigned entries_sent = 0;
    int unsigned blocks_checked = 0;
    int unsigned settings_written = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_request = 0;
    int unsigned stall_left = 0;
    bit idle_on = 1'b1;

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (hold_request > 0) begin
            stall_left = hold_request - 1;
            hold_request = 0;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 17);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic [SUM_W-1:0] add_capped(input longint unsigned a,
                                                    input longint unsigned b,
                                                    input longint unsigned cap);
        longint unsigned s;
        s = a + b;
        return (s > cap) ? cap[SUM_W-1:0] : s[SUM_W-1:0];
    endfunction

    function automatic int unsigned seq_in_use();
        int unsigned n;
        n = seq_reg;
        if (n < 2) n = 2;
        if (n > MAX_SEQ) n = MAX_SEQ;
        return n;
    endfunction

    task automatic close_column(input int unsigned n);
        blk_pairs_matched = PAIR_W'(add_capped(blk_pairs_matched, col_matched, PAIR_CAP));
        blk_pairs_total = PAIR_W'(add_capped(blk_pairs_total, col_pairs, PAIR_CAP));
        if (col_pairs > 0) begin
            blk_cols_total = COLW_W'(add_capped(blk_cols_total, n, COLW_CAP));
            if (col_matched == col_pairs)
                blk_cols_matched = COLW_W'(add_capped(blk_cols_matched, n, COLW_CAP));
        end
        if (cols_in_block != SEEN_MAX) cols_in_block++;
        col_pairs = '0;
        col_matched = '0;
        slot = 0;
    endtask

    // Updates the predicted scores with one accepted entry.
    task automatic score_entry(input entry_t e);
        int unsigned n;
        result_t r;
        bit counted;
        n = seq_in_use();
        if (slot >= n) slot = n - 1;
        if (e.ref_residue) begin
            for (int k = 0; k < slot; k++) begin
                if (held_residue[k]) begin
                    col_pairs++;
                    if (held_column[k] == e.test_column) col_matched++;
                end
            end
        end
        held_residue[slot] = e.ref_residue;
        held_column[slot] = e.ref_residue ? e.test_column : '0;
        slot++;
        if (slot >= n || e.block_end) close_column(n);
        if (e.block_end) begin
            counted = (cols_in_block > 1);
            if (counted) begin
                run_pairs_matched = add_capped(run_pairs_matched, blk_pairs_matched, SUM_CAP);
                run_pairs_total = add_capped(run_pairs_total, blk_pairs_total, SUM_CAP);
                run_cols_matched = add_capped(run_cols_matched, blk_cols_matched, SUM_CAP);
                run_cols_total = add_capped(run_cols_total, blk_cols_total, SUM_CAP);
            end
            r.block_counted = counted;
            r.block_pairs_matched = blk_pairs_matched;
            r.block_pairs_total = blk_pairs_total;
            r.block_columns_matched = blk_cols_matched;
            r.block_columns_total = blk_cols_total;
            r.sum_pairs_matched = run_pairs_matched;
            r.sum_pairs_total = run_pairs_total;
            r.sum_columns_matched = run_cols_matched;
            r.sum_columns_total = run_cols_total;
            expected_blocks.push_back(r);
            blk_pairs_matched = '0;
            blk_pairs_total = '0;
            blk_cols_matched = '0;
            blk_cols_total = '0;
            cols_in_block = '0;
            slot = 0;
            col_pairs = '0;
            col_matched = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                               input logic [SUM_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : check_result
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_blocks.size() == 0) begin
                $error("result beat with no block pending");
                fail_count++;
            end else begin
                want = expected_blocks.pop_front();
                blocks_checked++;
                check_field("block_counted", want.block_counted, m_data.block_counted);
                check_field("block_pairs_matched", want.block_pairs_matched,
                            m_data.block_pairs_matched);
                check_field("block_pairs_total", want.block_pairs_total,
                            m_data.block_pairs_total);
                check_field("block_columns_matched", want.block_columns_matched,
                            m_data.block_columns_matched);
                check_field("block_columns_total", want.block_columns_total,
                            m_data.block_columns_total);
                check_field("sum_pairs_matched", want.sum_pairs_matched,
                            m_data.sum_pairs_matched);
                check_field("sum_pairs_total", want.sum_pairs_total, m_data.sum_pairs_total);
                check_field("sum_columns_matched", want.sum_columns_matched,
                            m_data.sum_columns_matched);
                check_field("sum_columns_total", want.sum_columns_total,
                            m_data.sum_columns_total);
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with the beat taken.
    task automatic send_entry(input entry_t e);
        s_data <= e;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        score_entry(e);
        entries_sent++;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
    endtask

    task automatic send_fields(input logic residue, input logic [COL_W-1:0] column,
                               input logic last);
        entry_t e;
        e.ref_residue = residue;
        e.test_column = column;
        e.block_end = last;
        send_entry(e);
    endtask

    // Waits for every pending block and for the cell chain to empty.
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        while (expected_blocks.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr[APB_ADDR_W-1:2] == REG_BLOCK_SEQUENCES) seq_reg = value[CFG_SEQ_W-1:0];
        settings_written++;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_register_readback();
        logic [APB_DATA_W-1:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= SEQ_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        check_field("block_sequences", {{(APB_DATA_W - CFG_SEQ_W){1'b0}}, seq_reg}, got);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [COL_W-1:0] pick_base();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return COL_W'($urandom_range(0, (1 << COL_W) - 1));
        endcase
    endfunction

    // One block: columns with shared or nearby test columns so that pairs match often.
    // Now and then the block ends partway through a column.
    task automatic send_random_block(input int unsigned max_cols);
        int unsigned n;
        int unsigned ncols;
        int unsigned cut;
        int unsigned idx;
        logic [COL_W-1:0] base;
        bit uniform;
        bit broken;
        entry_t e;
        n = seq_in_use();
        ncols = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, max_cols);
        broken = ($urandom_range(0, 7) == 0);
        cut = $urandom_range(0, ncols * n - 1);
        for (int c = 0; c < ncols; c++) begin
            base = pick_base();
            uniform = ($urandom_range(0, 2) == 0);
            for (int j = 0; j < n; j++) begin
                idx = c * n + j;
                e.ref_residue = ($urandom_range(0, 3) != 0);
                if (uniform || $urandom_range(0, 1) == 0)
                    e.test_column = COL_W'(base + (uniform ? 0 : $urandom_range(0, 1)));
                else
                    e.test_column = COL_W'($urandom_range(0, (1 << COL_W) - 1));
                e.block_end = broken ? (idx == cut) : (c == ncols - 1 && j == n - 1);
                send_entry(e);
                if (e.block_end) return;
            end
        end
    endtask

    task automatic test_reset_state();
        check_register_readback();
    endtask

    // Hand-built blocks with three sequences per column.
    task automatic test_directed_blocks();
        write_register(SEQ_ADDR, 3);
        check_register_readback();
        // Single-column block: scored but not added to the totals.
        send_fields(1, 7, 0);
        send_fields(1, 7, 0);
        send_fields(1, 7, 1);
        // A gap that carries the same code as a residue must not pair with it.
        send_fields(0, 9, 0);
        send_fields(1, 9, 0);
        send_fields(1, 9, 0);
        send_fields(1, 0, 0);
        send_fields(1, '1, 0);
        send_fields(0, 0, 1);
        // Block end partway through the second column.
        send_fields(1, '1, 0);
        send_fields(1, '1, 0);
        send_fields(1, '1, 0);
        send_fields(1, 100, 1);
        // Mostly gaps: two columns without any pair.
        send_fields(0, '1, 0);
        send_fields(0, 0, 0);
        send_fields(0, 5, 0);
        send_fields(0, 5, 0);
        send_fields(0, 5, 0);
        send_fields(1, 5, 1);
        wait_until_idle();
    endtask

    // Settings outside the legal range are clamped; an unmapped address is ignored.
    task automatic test_register_range();
        logic [CFG_SEQ_W-1:0] settings [6] = '{0, 1, 127, 65, 64, 2};
        foreach (settings[i]) begin
            write_register(SEQ_ADDR, settings[i]);
            check_register_readback();
            send_random_block(3);
            wait_until_idle();
        end
        write_register(UNMAPPED_ADDR, 9);
        check_register_readback();
        send_random_block(4);
        wait_until_idle();
    endtask

    // The setting drops below the number of entries already held in the open column.
    task automatic test_lowered_mid_column();
        write_register(SEQ_ADDR, 5);
        send_fields(1, 20, 0);
        send_fields(1, 20, 0);
        send_fields(1, 21, 0);
        wait_until_idle();
        write_register(SEQ_ADDR, 2);
        send_fields(1, 20, 0);
        send_fields(1, 33, 0);
        send_fields(1, 33, 1);
        wait_until_idle();
    endtask

    // Results are held off long enough for the chain to fill and the input to stall.
    task automatic test_output_hold();
        write_register(SEQ_ADDR, 2);
        idle_on = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (30) send_random_block(3);
        idle_on = 1'b1;
        wait_until_idle();
    endtask

    // A block of many two-entry columns sent back to back.
    task automatic test_long_block();
        entry_t e;
        write_register(SEQ_ADDR, 2);
        idle_on = 1'b0;
        for (int c = 0; c < LONG_COLS; c++) begin
            for (int j = 0; j < 2; j++) begin
                e.ref_residue = ($urandom_range(0, 3) != 0);
                e.test_column = COL_W'($urandom_range(0, 3));
                e.block_end = (c == LONG_COLS - 1 && j == 1);
                send_entry(e);
            end
        end
        send_random_block(3);
        idle_on = 1'b1;
        wait_until_idle();
    endtask

    task automatic test_random_traffic(input logic [CFG_SEQ_W-1:0] setting,
                                       input int unsigned budget, input bit idling);
        int unsigned start;
        write_register(SEQ_ADDR, setting);
        idle_on = idling;
        start = entries_sent;
        while (entries_sent - start < budget)
            send_random_block(seq_in_use() > 16 ? 3 : 6);
        wait_until_idle();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        seq_reg = SEQ_RESET;
        slot = 0;
        col_pairs = '0;
        col_matched = '0;
        cols_in_block = '0;
        blk_pairs_matched = '0;
        blk_pairs_total = '0;
        blk_cols_matched = '0;
        blk_cols_total = '0;
        run_pairs_matched = '0;
        run_pairs_total = '0;
        run_cols_matched = '0;
        run_cols_total = '0;
        for (int k = 0; k < MAX_SEQ; k++) begin
            held_residue[k] = 1'b0;
            held_column[k] = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_directed_blocks();
        test_register_range();
        test_lowered_mid_column();
        test_output_hold();
        test_long_block();
        test_random_traffic(2, 100, 1'b1);
        test_random_traffic(64, 150, 1'b1);
        test_random_traffic(3, 100, 1'b1);
        test_random_traffic(CFG_SEQ_W'($urandom_range(4, 12)), 100, 1'b1);
        test_random_traffic(127, 80, 1'b1);
        test_random_traffic(CFG_SEQ_W'($urandom_range(2, 64)), 100, 1'b1);
        test_random_traffic(5, 120, 1'b0);

        $display("Checked %0d block results from %0d entries over %0d register writes,",
                 blocks_checked, entries_sent, settings_written);
        $display("with clamped settings, partial columns, random stalls and a long output hold.");
        if (fail_count == 0 && expected_blocks.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
